FILE: rtl/core/ahdsr_pkg.sv
// ----------------------------------------------------------------------------
// AHDSR envelope package
// Shared widths, register indexes, commands, stage codes and controller types.
// ----------------------------------------------------------------------------
package ahdsr_pkg;

  localparam int unsigned COUNT_BITS_DEF = 24;
  localparam int unsigned LEVEL_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned CFG_DATA_BITS  = 24;

  localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUSTAIN = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CURVE   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOOP    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_VSENS   = 3'd7;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

  localparam logic [1:0] CURVE_SQUARED = 2'd1;
  localparam logic [1:0] CURVE_SQRT    = 2'd2;

  typedef enum logic [2:0] {
    ENV_IDLE    = 3'd0,
    ENV_ATTACK  = 3'd1,
    ENV_HOLD    = 3'd2,
    ENV_DECAY   = 3'd3,
    ENV_SUSTAIN = 3'd4,
    ENV_RELEASE = 3'd5
  } env_stage_e;

  // Datapath operation steps issued by the controller.
  typedef struct packed {
    logic note_on;   // latch velocity, enter attack
    logic note_off;  // latch release start, enter release
    logic div_start; // start count*ONE/len divide
    logic div_step;  // one restoring divide step
    logic shape;     // form phase and start shaping
    logic sqrt_step; // one square-root step
    logic mix;       // form the level product
    logic finish;    // commit level and stage
  } ahdsr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } ahdsr_status_t;

endpackage

FILE: rtl/core/ahdsr_ctrl.sv
// ----------------------------------------------------------------------------
// AHDSR controller
// Sequences one transaction at a time; a tick runs through divide, shape, square-root, mix and finish steps.
// ----------------------------------------------------------------------------
module ahdsr_ctrl import ahdsr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic [1:0]    s_cmd_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output ahdsr_cmd_t    cmd_o,
  input  ahdsr_status_t status_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_SHAPE = 6'b000100,
    S_SQRT  = 6'b001000,
    S_MIX   = 6'b010000,
    S_FIN   = 6'b100000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  assign s_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (s_cmd_i == CMD_NOTE_ON) begin
            cmd_o.note_on = 1'b1;
          end else if (s_cmd_i == CMD_NOTE_OFF) begin
            cmd_o.note_off = 1'b1;
          end else if (s_cmd_i == CMD_TICK) begin
            cmd_o.div_start = 1'b1;
            state_d = S_DIV;
          end else begin
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) state_d = S_SHAPE;
      end
      S_SHAPE: begin
        cmd_o.shape = 1'b1;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.sqrt_done) state_d = S_MIX;
      end
      S_MIX: begin
        cmd_o.mix = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/ahdsr_dp.sv
// ----------------------------------------------------------------------------
// AHDSR datapath
// Envelope state, serial divider, serial square root and level arithmetic.
// ----------------------------------------------------------------------------
module ahdsr_dp import ahdsr_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ahdsr_cmd_t            cmd_i,
  output ahdsr_status_t         status_o,
  input  logic [LEVEL_BITS-1:0] note_velocity_i,
  input  logic [COUNT_BITS-1:0] attack_i,
  input  logic [COUNT_BITS-1:0] hold_i,
  input  logic [COUNT_BITS-1:0] decay_i,
  input  logic [COUNT_BITS-1:0] release_i,
  input  logic [LEVEL_BITS-1:0] sustain_i,
  input  logic [1:0]            curve_i,
  input  logic                  loop_i,
  input  logic [LEVEL_BITS-1:0] vsens_i,
  output logic [LEVEL_BITS-1:0] level_o,
  output logic                  active_o
);

  localparam int unsigned LB  = LEVEL_BITS;
  localparam int unsigned CB  = COUNT_BITS;
  localparam int unsigned FB  = LB - 1;
  localparam int unsigned NB  = CB + FB;
  localparam int unsigned SB  = 2 * LB;
  localparam int unsigned NBW = $clog2(NB + 1);
  localparam int unsigned SIW = $clog2(LB + 1);
  localparam logic [LB-1:0] ONE = LB'(1) << FB;

  env_stage_e     stage_q, stage_d;
  logic [CB-1:0]  count_q, count_d;
  logic [LB-1:0]  vel_q, level_q, rstart_q, level_d;
  logic           active_q;

  // divider
  logic [NB-1:0]  quo_q;
  logic [CB:0]    rem_q;
  logic [NBW-1:0] dcnt_q;
  logic [CB-1:0]  len;
  logic [CB+1:0]  rtrial;
  // shaping
  logic [LB-1:0]  p_q, shp_q;
  logic [SB-1:0]  sx_q;
  logic [SB-1:0]  sr_q;
  logic [SIW-1:0] scnt_q;
  logic [SB+1:0]  strial;
  logic [SB-1:0]  prod_q;
  logic [LB-1:0]  st_q;

  logic [LB-1:0]  sus_sat, sens_sat, nv_sat, frac, p_n;
  logic [SB-1:0]  sprod, ev_prod;
  logic [LB:0]    ev_sum;
  logic [LB-1:0]  ev_new;

  assign sus_sat  = (sustain_i > ONE) ? ONE : sustain_i;
  assign sens_sat = (vsens_i > ONE) ? ONE : vsens_i;
  assign nv_sat   = (note_velocity_i > ONE) ? ONE : note_velocity_i;
  assign ev_prod  = SB'(sens_sat) * SB'(nv_sat);
  assign ev_sum   = (LB+1)'(ONE) - (LB+1)'(sens_sat) + (LB+1)'(ev_prod >> FB);
  assign ev_new   = ev_sum[LB-1:0];

  always_comb begin
    unique case (stage_q)
      ENV_ATTACK: len = attack_i;
      ENV_DECAY:  len = decay_i;
      default:    len = release_i;
    endcase
  end

  assign rtrial = {rem_q, quo_q[NB-1]} - {2'b0, len};
  assign status_o.div_done  = (dcnt_q == NBW'(1)) || (len == '0);
  assign status_o.sqrt_done = (scnt_q == SIW'(1));
  assign frac = (quo_q > NB'(ONE)) ? ONE : quo_q[LB-1:0];
  assign strial = {sr_q, sx_q[SB-1:SB-2]} - {{(SB-LB){1'b0}}, shp_q, 2'b01};

  always_comb begin
    unique case (stage_q)
      ENV_ATTACK: p_n = (len == '0) ? ONE : frac;
      default:    p_n = (len == '0) ? '0 : ONE - frac;
    endcase
  end

  assign sprod = SB'(sus_sat) * SB'(vel_q);

  function automatic logic [LB-1:0] curve_v();
    if (curve_i == CURVE_SQUARED) return LB'(prod_q >> FB);
    if (curve_i == CURVE_SQRT) return shp_q;
    return p_q;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q  <= NB'(count_q) << FB;
      rem_q  <= '0;
      dcnt_q <= NBW'(NB);
      st_q   <= LB'(sprod >> FB);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - NBW'(1);
      if (!rtrial[CB+1]) begin
        rem_q <= rtrial[CB:0];
        quo_q <= {quo_q[NB-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[CB-1:0], quo_q[NB-1]};
        quo_q <= {quo_q[NB-2:0], 1'b0};
      end
    end
    if (cmd_i.shape) begin
      p_q    <= p_n;
      prod_q <= SB'(p_n) * SB'(p_n);
      sx_q   <= SB'(p_n) << FB;
      sr_q   <= '0;
      shp_q  <= '0;
      scnt_q <= SIW'(LB);
    end else if (cmd_i.sqrt_step) begin
      scnt_q <= scnt_q - SIW'(1);
      sx_q   <= sx_q << 2;
      if (!strial[SB+1]) begin
        sr_q  <= strial[SB-1:0];
        shp_q <= {shp_q[LB-2:0], 1'b1};
      end else begin
        sr_q  <= {sr_q[SB-3:0], sx_q[SB-1:SB-2]};
        shp_q <= {shp_q[LB-2:0], 1'b0};
      end
    end else if (cmd_i.mix) begin
      unique case (stage_q)
        ENV_ATTACK:  prod_q <= SB'(curve_v()) * SB'(vel_q);
        ENV_DECAY:   prod_q <= SB'(vel_q - st_q) * SB'(curve_v());
        default:     prod_q <= SB'(rstart_q) * SB'(curve_v());
      endcase
    end
  end

  always_comb begin
    stage_d = stage_q;
    count_d = count_q;
    level_d = level_q;
    unique case (stage_q)
      ENV_ATTACK: begin
        level_d = LB'(prod_q >> FB);
        count_d = count_q + CB'(1);
        if (count_d >= attack_i) begin
          level_d = vel_q;
          stage_d = (hold_i != '0) ? ENV_HOLD : ENV_DECAY;
          count_d = '0;
        end
      end
      ENV_HOLD: begin
        level_d = vel_q;
        count_d = count_q + CB'(1);
        if (count_d >= hold_i) begin
          stage_d = ENV_DECAY;
          count_d = '0;
        end
      end
      ENV_DECAY: begin
        level_d = st_q + LB'(prod_q >> FB);
        count_d = count_q + CB'(1);
        if (count_d >= decay_i) begin
          level_d = st_q;
          stage_d = ENV_SUSTAIN;
          count_d = '0;
        end
      end
      ENV_SUSTAIN: level_d = st_q;
      ENV_RELEASE: begin
        level_d = LB'(prod_q >> FB);
        count_d = count_q + CB'(1);
        if (count_d >= release_i) begin
          if (loop_i) begin
            stage_d = ENV_ATTACK;
            count_d = '0;
          end else begin
            level_d = '0;
            stage_d = ENV_IDLE;
          end
        end
      end
      default: stage_d = ENV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= ENV_IDLE;
      count_q  <= '0;
      vel_q    <= '0;
      level_q  <= '0;
      rstart_q <= '0;
      active_q <= 1'b0;
    end else if (cmd_i.note_on) begin
      vel_q   <= ev_new;
      stage_q <= ENV_ATTACK;
      count_q <= '0;
    end else if (cmd_i.note_off) begin
      if (stage_q != ENV_IDLE) begin
        rstart_q <= level_q;
        stage_q  <= ENV_RELEASE;
        count_q  <= '0;
      end
    end else if (cmd_i.finish) begin
      stage_q  <= stage_d;
      count_q  <= count_d;
      level_q  <= level_d;
      active_q <= (stage_d != ENV_IDLE);
    end
  end

  assign level_o  = active_q ? level_q : '0;
  assign active_o = active_q;

endmodule

FILE: rtl/core/ahdsr_envelope_generator.sv
// ----------------------------------------------------------------------------
// AHDSR envelope generator
// Attack, hold, decay, sustain and release envelope with shaped curves.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// s_axis   in         tdata: cmd[1:0], note_velocity[17:2]
// m_axis   out        tdata: level[15:0], active[16]
// cfg      in         cfg_we_i, cfg_idx_i, cfg_data_i
// A note-on, note-off or unused command gives no result.
// A sample tick runs the serial phase divider (COUNT_BITS+LEVEL_BITS-1 steps,
// one step when the stage length is zero) and then the serial square-root
// unit (LEVEL_BITS steps) before its result is valid.
// A new transaction is taken once the previous result has been delivered.
// After reset the envelope is idle and the registers hold their defaults.
// ----------------------------------------------------------------------------
module ahdsr_envelope_generator import ahdsr_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((LEVEL_BITS+9)/8)*8-1:0]      s_axis_tdata,   // cmd, note_velocity
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((LEVEL_BITS+8)/8)*8-1:0]      m_axis_tdata,   // level, active
  input  logic                                 cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]              cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]             cfg_data_i
);

  localparam int unsigned OUT_W = ((LEVEL_BITS + 8) / 8) * 8;

  logic [COUNT_BITS-1:0] attack_q, hold_q, decay_q, release_q;
  logic [LEVEL_BITS-1:0] sustain_q, vsens_q, level;
  logic [1:0]            curve_q;
  logic                  loop_q, active;
  ahdsr_cmd_t            cmd;
  ahdsr_status_t         status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= '0;
      hold_q    <= '0;
      decay_q   <= '0;
      release_q <= '0;
      sustain_q <= LEVEL_BITS'(1) << (LEVEL_BITS - 1);
      curve_q   <= '0;
      loop_q    <= 1'b0;
      vsens_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ATTACK:  attack_q  <= COUNT_BITS'(cfg_data_i);
        REG_HOLD:    hold_q    <= COUNT_BITS'(cfg_data_i);
        REG_DECAY:   decay_q   <= COUNT_BITS'(cfg_data_i);
        REG_RELEASE: release_q <= COUNT_BITS'(cfg_data_i);
        REG_SUSTAIN: sustain_q <= LEVEL_BITS'(cfg_data_i[15:0]);
        REG_CURVE:   curve_q   <= cfg_data_i[1:0];
        REG_LOOP:    loop_q    <= cfg_data_i[0];
        REG_VSENS:   vsens_q   <= LEVEL_BITS'(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  ahdsr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_cmd_i   (s_axis_tdata[1:0]),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  ahdsr_dp #(
    .COUNT_BITS (COUNT_BITS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .note_velocity_i (s_axis_tdata[LEVEL_BITS+1:2]),
    .attack_i        (attack_q),
    .hold_i          (hold_q),
    .decay_i         (decay_q),
    .release_i       (release_q),
    .sustain_i       (sustain_q),
    .curve_i         (curve_q),
    .loop_i          (loop_q),
    .vsens_i         (vsens_q),
    .level_o         (level),
    .active_o        (active)
  );

  assign m_axis_tdata = OUT_W'({active, level});

endmodule

FILE: bench/ahdsr_checker.sv
// ----------------------------------------------------------------------------
// AHDSR envelope checker
// Watches the configuration port and both stream channels, keeps its own
// envelope predictor, and compares each delivered level with the oldest
// expected one.
// ----------------------------------------------------------------------------
module ahdsr_checker import ahdsr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  input  logic [23:0]              s_axis_tdata,   // cmd, note_velocity
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [23:0]              m_axis_tdata,   // level, active
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       checked_o
);

  localparam longint unsigned UNITY = 64'd32768;

  typedef struct {
    logic [15:0] level;
    logic        active;
  } env_sample_t;

  env_sample_t level_q[$];

  longint unsigned attack_len, hold_len, decay_len, release_len;
  longint unsigned sustain_reg, vsens_reg;
  logic [1:0]      curve_reg;
  logic            loop_reg;

  env_stage_e      stage;
  longint unsigned count, velocity, level, release_level;

  function automatic longint unsigned clamp_unity(longint unsigned v);
    return (v > UNITY) ? UNITY : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic longint unsigned curve_of(longint unsigned p);
    case (curve_reg)
      CURVE_SQUARED: return (p * p) / UNITY;
      CURVE_SQRT:    return int_sqrt(p * UNITY);
      default:       return p;
    endcase
  endfunction

  function automatic longint unsigned phase_of(longint unsigned c, longint unsigned len);
    longint unsigned f;
    f = (c * UNITY) / len;
    return (f > UNITY) ? UNITY : f;
  endfunction

  function automatic longint unsigned falling(longint unsigned len);
    if (len == 0) return 0;
    return UNITY - phase_of(count, len);
  endfunction

  task automatic advance_envelope();
    longint unsigned target, p;
    target = (clamp_unity(sustain_reg) * velocity) / UNITY;
    case (stage)
      ENV_ATTACK: begin
        p = (attack_len != 0) ? phase_of(count, attack_len) : UNITY;
        level = (curve_of(p) * velocity) / UNITY;
        count = (count + 1) & 64'hFFFFFF;
        if (count >= attack_len) begin
          level = velocity;
          stage = (hold_len > 0) ? ENV_HOLD : ENV_DECAY;
          count = 0;
        end
      end
      ENV_HOLD: begin
        level = velocity;
        count = (count + 1) & 64'hFFFFFF;
        if (count >= hold_len) begin
          stage = ENV_DECAY;
          count = 0;
        end
      end
      ENV_DECAY: begin
        p = falling(decay_len);
        level = target + ((velocity - target) * curve_of(p)) / UNITY;
        count = (count + 1) & 64'hFFFFFF;
        if (count >= decay_len) begin
          level = target;
          stage = ENV_SUSTAIN;
          count = 0;
        end
      end
      ENV_SUSTAIN: level = target;
      ENV_RELEASE: begin
        p = falling(release_len);
        level = (release_level * curve_of(p)) / UNITY;
        count = (count + 1) & 64'hFFFFFF;
        if (count >= release_len) begin
          if (loop_reg) begin
            stage = ENV_ATTACK;
            count = 0;
          end else begin
            level = 0;
            stage = ENV_IDLE;
          end
        end
      end
      default: stage = ENV_IDLE;
    endcase
    level = level & 64'hFFFF;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_len = 0;
      hold_len = 0;
      decay_len = 0;
      release_len = 0;
      sustain_reg = UNITY;
      curve_reg = '0;
      loop_reg = 1'b0;
      vsens_reg = 0;
      stage = ENV_IDLE;
      count = 0;
      velocity = 0;
      level = 0;
      release_level = 0;
      level_q.delete();
      errors_o = 0;
      checked_o = 0;
      pending_o = 0;
    end else begin
      env_sample_t got, want;
      logic [1:0]  cmd;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ATTACK:  attack_len = cfg_data_i;
          REG_HOLD:    hold_len = cfg_data_i;
          REG_DECAY:   decay_len = cfg_data_i;
          REG_RELEASE: release_len = cfg_data_i;
          REG_SUSTAIN: sustain_reg = cfg_data_i[15:0];
          REG_CURVE:   curve_reg = cfg_data_i[1:0];
          REG_LOOP:    loop_reg = cfg_data_i[0];
          REG_VSENS:   vsens_reg = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cmd = s_axis_tdata[1:0];
        if (cmd == CMD_NOTE_ON) begin
          velocity = (UNITY - clamp_unity(vsens_reg)
                      + (clamp_unity(vsens_reg) * clamp_unity(s_axis_tdata[17:2])) / UNITY)
                     & 64'hFFFF;
          stage = ENV_ATTACK;
          count = 0;
        end else if (cmd == CMD_NOTE_OFF) begin
          if (stage != ENV_IDLE) begin
            release_level = level;
            stage = ENV_RELEASE;
            count = 0;
          end
        end else if (cmd == CMD_TICK) begin
          advance_envelope();
          want.active = (stage != ENV_IDLE);
          want.level = want.active ? level[15:0] : 16'd0;
          level_q.push_back(want);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.level = m_axis_tdata[15:0];
        got.active = m_axis_tdata[16];
        if (level_q.size() == 0) begin
          $error("Unexpected result transaction: level %0d active %0d",
                 got.level, got.active);
          errors_o++;
        end else begin
          want = level_q.pop_front();
          checked_o++;
          if (got.level !== want.level) begin
            $error("level mismatch: expected %0d, actual %0d", want.level, got.level);
            errors_o++;
          end
          if (got.active !== want.active) begin
            $error("active mismatch: expected %0d, actual %0d", want.active, got.active);
            errors_o++;
          end
        end
      end
      pending_o = level_q.size();
    end
  end

endmodule

FILE: bench/tb_ahdsr_envelope_generator.sv
// ----------------------------------------------------------------------------
// AHDSR envelope generator testbench
// Drives directed and random note and tick sequences under several register
// settings with random stalls on both channels; a checker predicts levels.
// ----------------------------------------------------------------------------
module tb_ahdsr_envelope_generator;
  import ahdsr_pkg::*;

  localparam int          CYCLE_LIMIT = 3000000;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  logic                     clk_i, rst_ni;
  logic                     s_axis_tvalid, s_axis_tready;
  logic [23:0]              s_axis_tdata;
  logic                     m_axis_tvalid, m_axis_tready;
  logic [23:0]              m_axis_tdata;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  int errors, pending, checked, phases, cycles;
  bit calm;

  ahdsr_envelope_generator uut (.*);

  ahdsr_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int stall;
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (phases == 6 && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      stall = calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [15:0] vel);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, vel, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input int a, input int h, input int d, input int r,
                           input int sus, input int crv, input int lp, input int vs);
    drain();
    write_reg(REG_ATTACK, CFG_DATA_BITS'(a));
    write_reg(REG_HOLD, CFG_DATA_BITS'(h));
    write_reg(REG_DECAY, CFG_DATA_BITS'(d));
    write_reg(REG_RELEASE, CFG_DATA_BITS'(r));
    write_reg(REG_SUSTAIN, CFG_DATA_BITS'(sus));
    write_reg(REG_CURVE, CFG_DATA_BITS'(crv));
    write_reg(REG_LOOP, CFG_DATA_BITS'(lp));
    write_reg(REG_VSENS, CFG_DATA_BITS'(vs));
    phases++;
  endtask

  function automatic int rand_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 0;
    if (pick == 1) return 24'hFFFFFF;
    if (pick == 2) return $urandom_range(0, 24'hFFFFFF);
    return $urandom_range(1, 12);
  endfunction

  function automatic int rand_q15();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 32768;
      2: return $urandom_range(32769, 65535);
      default: return $urandom_range(0, 32768);
    endcase
  endfunction

  initial begin
    int left, n;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(CMD_TICK, 16'd0);
    send(CMD_NOTE_OFF, 16'd0);
    send(CMD_UNUSED, 16'hFFFF);
    send(CMD_NOTE_ON, 16'd20000);
    repeat (3) send(CMD_TICK, 16'd0);
    configure(4, 2, 5, 3, 16384, CURVE_SQUARED, 1, 32768);
    send(CMD_NOTE_ON, 16'hFFFF);
    repeat (14) send(CMD_TICK, 16'd0);
    send(CMD_NOTE_ON, 16'd0);
    send(CMD_TICK, 16'd0);
    send(CMD_NOTE_OFF, 16'd0);
    send(CMD_TICK, 16'd0);
    send(CMD_NOTE_OFF, 16'd0);
    repeat (6) send(CMD_TICK, 16'd0);

    configure(0, 0, 0, 0, 0, 0, 0, 0);
    send(CMD_NOTE_ON, 16'd32768);
    repeat (4) send(CMD_TICK, 16'd0);
    configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 3, 1, 16'hFFFF);
    repeat (3) send(CMD_TICK, 16'd0);

    left = 1600;
    while (left > 0) begin
      configure(rand_len(), $urandom_range(0, 3) == 0 ? 0 : rand_len(), rand_len(),
                rand_len(), rand_q15(), $urandom_range(0, 3), $urandom_range(0, 1),
                rand_q15());
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 140 && left > 0; k++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            send(CMD_NOTE_ON, 16'(rand_q15()));
            left--;
          end
          3, 4: begin
            send(CMD_NOTE_OFF, 16'($urandom));
            left--;
          end
          5: begin
            send(CMD_UNUSED, 16'($urandom));
          end
          6: begin
            if (k == 70) drain();
          end
          default: begin
            n = $urandom_range(1, 12);
            repeat (n) send(CMD_TICK, 16'($urandom));
            left -= n;
          end
        endcase
      end
    end

    drain();
    $display("Checked %0d level results over %0d register settings,", checked, phases);
    $display("covering all commands, curve modes, loop mode and stalls on both sides.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
